// ===== hw/rtl/rbsa_pkg.sv =====
// Shared types and codes for the rotating bitmap slot allocator.
package rbsa_pkg;

  typedef enum logic [1:0] {
    FUNC_ALLOC     = 2'd0,
    FUNC_RELEASE   = 2'd1,
    FUNC_CLEAR_ALL = 2'd2,
    FUNC_TEST      = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_SCAN,
    ST_TEST_READ,
    ST_REPLY
  } state_t;

  localparam int SLOT_W = 6;

  typedef struct packed {
    func_t             func;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] given_slot;
    logic              success;
    logic              slot_in_use;
  } rsp_t;

endpackage

// ===== hw/rtl/rbsa_map_ram.sv =====
// Used-slot bitmap storage: one write port, one registered read port.
module rbsa_map_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_bit,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_bit
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
  end

  // registered read; a read and a write at one address return the old bit
  always_ff @(posedge clk) begin
    rd_bit <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/rotating_bitmap_slot_allocator.sv =====
// Top level of the rotating (next-fit) bitmap slot allocator.
//
// Usage:
//   Requests come in on req (func, slot_index) under req_valid/req_stall;
//   one response per request leaves on rsp under rsp_valid/rsp_stall. A
//   transfer happens at a clock edge where valid is high and stall is low.
//   Operations: allocate, release one slot, clear all slots, test one slot.
//   The block handles one request at a time and stalls req until it is done.
// From request transfer to response valid:
//   release clears the slot, test reads it, clear-all sweeps every slot and
//   allocate probes k slots (1 .. TOP_SLOT-FIRST_SLOT+1); each then replies.
//   A new request can transfer in the cycle after the response is loaded.
//   The bitmap has one read port and the probe walks it one slot per cycle,
//   so allocate time is set by how far the pointer travels to a clear bit.
// Reset:
//   rst is synchronous. After it the block sweeps the bitmap to zero, one
//   slot per cycle, holding req_stall high meanwhile.
//   The search pointer resets to zero.
// Back pressure:
//   A finished response sits in the output register while rsp_stall is
//   high; the next request is still taken and its result waits internally
//   until the output register frees up.
module rotating_bitmap_slot_allocator #(
  parameter int TOP_SLOT   = 63,
  parameter int FIRST_SLOT = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rbsa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rbsa_pkg::rsp_t rsp
);

  import rbsa_pkg::*;

  localparam int DEPTH = TOP_SLOT + 1;
  localparam int PW    = $clog2(DEPTH);
  localparam int ROUND = TOP_SLOT - FIRST_SLOT + 1;
  localparam int CW    = (ROUND > 1) ? $clog2(ROUND) : 1;
  localparam int IW    = (PW > SLOT_W) ? PW : SLOT_W;

  localparam logic [PW-1:0] TOP_ADDR   = PW'(TOP_SLOT);
  localparam logic [PW-1:0] FIRST_ADDR = PW'(FIRST_SLOT);
  localparam logic [CW-1:0] LAST_PROBE = CW'(ROUND - 1);

  state_t        state, state_next;
  logic [PW-1:0] ptr, ptr_next;       // last slot handed out, or last slot probed in a full round
  logic [PW-1:0] cand, cand_next;     // slot whose bit is being read
  logic [CW-1:0] cnt, cnt_next;       // probes done this round
  logic [PW-1:0] clr_addr, clr_addr_next;
  logic          clr_reply, clr_reply_next;
  logic          idx_ok, idx_ok_next;
  rsp_t          res, res_next;
  rsp_t          rsp_next;
  logic          rsp_valid_next;

  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic          wr_bit;
  logic [PW-1:0] rd_addr;
  logic          rd_bit;

  logic          req_take;
  logic          req_idx_ok;
  logic [PW-1:0] req_addr;
  logic          rsp_free;

  rbsa_map_ram #(
    .DEPTH (DEPTH),
    .AW    (PW)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_bit  (wr_bit),
    .rd_addr (rd_addr),
    .rd_bit  (rd_bit)
  );

  // step the pointer, wrapping past the top slot to the first slot
  function automatic logic [PW-1:0] step_slot(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    n = (p == TOP_ADDR) ? FIRST_ADDR : p + PW'(1);
    return n;
  endfunction

  assign req_stall  = (state != ST_IDLE);
  assign req_take   = req_valid && !req_stall;
  // indices past the top slot read as clear and are never written
  assign req_idx_ok = (IW'(req.slot_index) <= IW'(TOP_SLOT));
  assign req_addr   = PW'(req.slot_index);
  assign rsp_free   = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      ptr       <= '0;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      clr_addr  <= clr_addr_next;
      clr_reply <= clr_reply_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cand   <= cand_next;
    cnt    <= cnt_next;
    idx_ok <= idx_ok_next;
    res    <= res_next;
    rsp    <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    cand_next      = cand;
    cnt_next       = cnt;
    clr_addr_next  = clr_addr;
    clr_reply_next = clr_reply;
    idx_ok_next    = idx_ok;
    res_next       = res;
    rsp_next       = rsp;
    // drop the output once it is taken
    rsp_valid_next = rsp_valid && rsp_stall;
    wr_en          = 1'b0;
    wr_addr        = cand;
    wr_bit         = 1'b0;
    rd_addr        = cand;

    case (state)
      ST_CLEAR: begin
        // sweep one slot per cycle
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        if (clr_addr == TOP_ADDR) begin
          clr_addr_next = '0;
          if (clr_reply) begin
            clr_reply_next = 1'b0;
            res_next       = '0;
            state_next     = ST_REPLY;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          clr_addr_next = clr_addr + PW'(1);
        end
      end

      ST_IDLE: begin
        if (req_take) begin
          res_next = '0;
          case (req.func)
            FUNC_ALLOC: begin
              // read the first candidate now; its bit arrives next cycle
              cand_next  = step_slot(ptr);
              rd_addr    = step_slot(ptr);
              cnt_next   = '0;
              state_next = ST_ALLOC_SCAN;
            end
            FUNC_RELEASE: begin
              wr_en      = req_idx_ok;
              wr_addr    = req_addr;
              state_next = ST_REPLY;
            end
            FUNC_CLEAR_ALL: begin
              clr_reply_next = 1'b1;
              state_next     = ST_CLEAR;
            end
            FUNC_TEST: begin
              rd_addr     = req_addr;
              idx_ok_next = req_idx_ok;
              state_next  = ST_TEST_READ;
            end
            default: begin
              state_next = ST_REPLY;
            end
          endcase
        end
      end

      ST_ALLOC_SCAN: begin
        // rd_bit belongs to cand; prefetch the following slot meanwhile
        rd_addr = step_slot(cand);
        if (!rd_bit) begin
          wr_en                = 1'b1;
          wr_addr              = cand;
          wr_bit               = 1'b1;
          ptr_next             = cand;
          res_next.given_slot  = SLOT_W'(cand);
          res_next.success     = 1'b1;
          res_next.slot_in_use = 1'b0;
          state_next           = ST_REPLY;
        end else if (cnt == LAST_PROBE) begin
          // full round without a clear bit
          ptr_next   = cand;
          res_next   = '0;
          state_next = ST_REPLY;
        end else begin
          cnt_next  = cnt + CW'(1);
          cand_next = step_slot(cand);
        end
      end

      ST_TEST_READ: begin
        res_next             = '0;
        res_next.slot_in_use = rd_bit && idx_ok;
        state_next           = ST_REPLY;
      end

      ST_REPLY: begin
        // hold the result until the output register is free
        if (rsp_free) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // the reset sweep keeps requests out
  a_reset_stalls: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request channel open right after reset");

  // only a successful allocate sets a bit, and only over a clear one
  a_set_only_on_free: assert property (@(posedge clk) disable iff (rst)
    (wr_en && wr_bit) |-> (state == ST_ALLOC_SCAN && !rd_bit))
    else $error("bitmap bit set outside a free-slot allocate");

  // the probe never runs past one round nor past the top slot
  a_probe_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALLOC_SCAN) |-> (cnt <= LAST_PROBE && cand <= TOP_ADDR))
    else $error("allocate probe out of bounds");

  // test answers and allocate answers never mix in one response
  a_rsp_exclusive: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.slot_in_use) |-> (!rsp.success && rsp.given_slot == '0))
    else $error("response mixes test and allocate fields");

  // a new response is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPLY && rsp_valid && rsp_stall) |=> (state == ST_REPLY))
    else $error("result left its hold while output was stalled");

endmodule

// ===== tb/rotating_bitmap_slot_allocator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the rotating bitmap slot allocator.
module rotating_bitmap_slot_allocator_test;
  import rbsa_pkg::*;

  localparam int TOP_SLOT   = 63;
  localparam int FIRST_SLOT = 1;
  // Slowest operation (full scan or clear-all) plus margin.
  localparam int DRAIN_CYCLES = TOP_SLOT + 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  rotating_bitmap_slot_allocator #(
    .TOP_SLOT  (TOP_SLOT),
    .FIRST_SLOT(FIRST_SLOT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #2 clk = ~clk;

  // Requests waiting to be driven, and responses predicted but not yet seen.
  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  // Handshake bookkeeping: a request is outstanding while offered != accepted.
  int offered_cnt  = 0;
  int accepted_cnt = 0;

  // Idle and stall rates for the current phase, in percent.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long response hold-off, started once by the stimulus.
  logic hold_start = 1'b0;
  logic hold_done  = 1'b0;
  int   hold_left  = 0;

  int error_count = 0;
  int checked_cnt = 0;
  int n_alloc_ok = 0, n_alloc_full = 0, n_release = 0, n_clear = 0, n_test = 0;

  // Shadow of the block's state: one used bit per slot and the search pointer.
  logic [TOP_SLOT:0]  slot_used;
  logic [SLOT_W-1:0]  search_ptr;

  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  // Apply one request to the shadow state and return the response it must give.
  function automatic rsp_t apply_slot_request(req_t r);
    rsp_t res;
    int   probes;
    res = '0;
    case (r.func)
      FUNC_ALLOC: begin
        // Advance first, wrap past the top back to the first slot, and stop
        // at the first clear bit; give up after one full round.
        for (probes = 0; probes < TOP_SLOT - FIRST_SLOT + 1; probes++) begin
          if (search_ptr >= TOP_SLOT) begin
            search_ptr = SLOT_W'(FIRST_SLOT);
          end else begin
            search_ptr = search_ptr + 1'b1;
          end
          if (!slot_used[search_ptr]) begin
            slot_used[search_ptr] = 1'b1;
            res.given_slot = search_ptr;
            res.success    = 1'b1;
            break;
          end
        end
        if (res.success) n_alloc_ok++;
        else n_alloc_full++;
      end
      FUNC_RELEASE: begin
        if (r.slot_index <= TOP_SLOT) slot_used[r.slot_index] = 1'b0;
        n_release++;
      end
      FUNC_CLEAR_ALL: begin
        // Pointer is left where it is.
        slot_used = '0;
        n_clear++;
      end
      default: begin
        if (r.slot_index <= TOP_SLOT) res.slot_in_use = slot_used[r.slot_index];
        n_test++;
      end
    endcase
    return res;
  endfunction

  // Drive requests on the falling edge; hold the payload until it transfers.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || offered_cnt == accepted_cnt) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req         <= pending_reqs.pop_front();
        req_valid   <= 1'b1;
        offered_cnt <= offered_cnt + 1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Stall responses at random, and solidly during the long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Count the hold-off in its own process so the sender keeps offering.
  always @(posedge clk) begin
    if (hold_start && !hold_done && hold_left == 0) begin
      hold_left <= 400;
    end else if (hold_left == 1) begin
      hold_left <= 0;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Sample both channels on the rising edge: check each response transfer
  // against the oldest prediction, then predict for each request transfer.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("response with nothing outstanding: slot %0d ok %0b use %0b",
                                    rsp.given_slot, rsp.success, rsp.slot_in_use));
        end else begin
          want = expected_rsps.pop_front();
          checked_cnt++;
          if (rsp.given_slot !== want.given_slot)
            report_mismatch($sformatf("given_slot got %0d want %0d",
                                      rsp.given_slot, want.given_slot));
          if (rsp.success !== want.success)
            report_mismatch($sformatf("success got %0b want %0b", rsp.success, want.success));
          if (rsp.slot_in_use !== want.slot_in_use)
            report_mismatch($sformatf("slot_in_use got %0b want %0b",
                                      rsp.slot_in_use, want.slot_in_use));
        end
      end
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(apply_slot_request(req));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  task automatic queue_req(func_t f, logic [SLOT_W-1:0] idx);
    req_t r;
    r.func       = f;
    r.slot_index = idx;
    pending_reqs.push_back(r);
  endtask

  // Mostly allocate/release/test traffic; occasional long allocate runs fill
  // the map and push allocations past it, and rare clear-alls empty it again.
  task automatic queue_random_mix(int n_items);
    int made;
    int pick;
    int burst;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        burst = $urandom_range(70, 64);
        repeat (burst) queue_req(FUNC_ALLOC, SLOT_W'($urandom));
        made += burst;
      end else if (pick < 40) begin
        burst = $urandom_range(6, 1);
        repeat (burst) queue_req(FUNC_ALLOC, SLOT_W'($urandom));
        made += burst;
      end else if (pick < 68) begin
        queue_req(FUNC_RELEASE, SLOT_W'($urandom));
        made++;
      end else if (pick < 97) begin
        queue_req(FUNC_TEST, SLOT_W'($urandom));
        made++;
      end else begin
        queue_req(FUNC_CLEAR_ALL, SLOT_W'($urandom));
        made++;
      end
    end
  endtask

  // Wait until every request has transferred and every response has come back.
  task automatic wait_for_drain();
    while (pending_reqs.size() != 0 || offered_cnt != accepted_cnt ||
           expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    slot_used  = '0;
    search_ptr = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed: slot zero and the top slot, first allocations, release and
    // test of slots the allocator never hands out, clear-all keeping the
    // pointer, and all-ones / alternating index patterns.
    queue_req(FUNC_TEST, 6'd0);
    queue_req(FUNC_TEST, 6'h3F);
    queue_req(FUNC_ALLOC, 6'h3F);
    queue_req(FUNC_ALLOC, 6'h00);
    queue_req(FUNC_TEST, 6'd1);
    queue_req(FUNC_TEST, 6'd2);
    queue_req(FUNC_RELEASE, 6'd1);
    queue_req(FUNC_TEST, 6'd1);
    queue_req(FUNC_RELEASE, 6'd0);
    queue_req(FUNC_RELEASE, 6'h3F);
    queue_req(FUNC_ALLOC, 6'h2A);
    queue_req(FUNC_TEST, 6'h15);
    queue_req(FUNC_CLEAR_ALL, 6'h3F);
    queue_req(FUNC_TEST, 6'd3);
    queue_req(FUNC_ALLOC, 6'h15);
    queue_req(FUNC_TEST, 6'd4);
    queue_req(FUNC_RELEASE, 6'h2A);
    queue_req(FUNC_TEST, 6'h2A);
    queue_req(FUNC_CLEAR_ALL, 6'h00);

    // Phase: no idling on either side, with one long response hold-off.
    queue_random_mix(270);
    wait (accepted_cnt >= 60);
    hold_start = 1'b1;
    wait_for_drain();

    // Phase: sender idle most cycles.
    send_idle_pct  = 62;
    recv_stall_pct = 0;
    queue_random_mix(270);
    wait_for_drain();

    // Phase: receiver stalling most cycles.
    send_idle_pct  = 0;
    recv_stall_pct = 62;
    queue_random_mix(270);
    wait_for_drain();

    // Phase: light idling on both sides.
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    queue_random_mix(270);
    wait_for_drain();

    // Let any stray response show up before judging.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_rsps.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));

    $display("Ran %0d requests: %0d allocations granted, %0d refused on a full map,",
             accepted_cnt, n_alloc_ok, n_alloc_full);
    $display("%0d releases, %0d clear-alls, %0d tests; %0d responses checked.",
             n_release, n_clear, n_test, checked_cnt);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #2000000;
    $display("Timeout after %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

endmodule
